### hdl/gss_pkg.sv
// ---------------------------------------------------------------------------
// gss_pkg
// Shared constants, curve tables and pipeline item types of the shift
// scheduler.
// ---------------------------------------------------------------------------
package gss_pkg;

    localparam int CURVE_POINTS = 11;
    localparam int CURVE_COUNT  = 6;

    localparam int SPEED_W = 7;   // saturated speed, 0..120
    localparam int LOAD_W  = 10;
    localparam int SEG_W   = 4;   // segment number, 0..CURVE_POINTS-1
    localparam int FRAC_W  = 7;   // weight inside a segment, 0..LOAD_STEP-1
    localparam int VAL_W   = 14;  // curve value in 1/LOAD_STEP units
    localparam int PRES_W  = 7;
    localparam int GEAR_W  = 3;
    localparam int CURVE_W = 3;

    localparam logic [7:0]        SPEED_IN_MAX = 8'd120;
    localparam logic [LOAD_W-1:0] LOAD_MAX     = 10'd1000;

    // load tenths per segment, also the scale of one curve unit
    localparam int LOAD_STEP = 1000 / (CURVE_POINTS - 1);

    localparam logic [SEG_W-1:0] LAST_POINT = SEG_W'(CURVE_POINTS - 1);

    // floor(load / LOAD_STEP) as a multiply and shift, exact for load <= 1000
    localparam int SEG_RECIP = 41;
    localparam int SEG_SHIFT = 12;

    // floor(value / LOAD_STEP), exact for value < 2**VAL_W
    localparam int PRES_RECIP = 10486;
    localparam int PRES_SHIFT = 20;

    localparam logic [GEAR_W-1:0] GEAR_1 = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_2 = 3'd2;
    localparam logic [GEAR_W-1:0] GEAR_3 = 3'd3;
    localparam logic [GEAR_W-1:0] GEAR_4 = 3'd4;

    typedef enum logic [CURVE_W-1:0] {
        CURVE_12_UP = 3'd0,
        CURVE_21_DN = 3'd1,
        CURVE_23_UP = 3'd2,
        CURVE_32_DN = 3'd3,
        CURVE_34_UP = 3'd4,
        CURVE_43_DN = 3'd5
    } t_curve;

    localparam logic [SPEED_W-1:0] SPEED_TAB [CURVE_COUNT][CURVE_POINTS] = '{
        '{3, 3, 3, 4, 4, 4, 6, 7, 11, 17, 28},
        '{1, 1, 1, 2, 2, 2, 2, 2, 3, 6, 12},
        '{14, 11, 12, 15, 21, 27, 33, 40, 48, 58, 68},
        '{8, 8, 9, 9, 9, 11, 13, 15, 20, 28, 47},
        '{30, 29, 31, 41, 51, 60, 75, 85, 93, 100, 100},
        '{20, 20, 23, 30, 39, 47, 55, 60, 66, 74, 79}
    };

    localparam logic [PRES_W-1:0] PRES_TAB [CURVE_COUNT][CURVE_POINTS] = '{
        '{10, 10, 10, 10, 10, 20, 20, 20, 30, 30, 40},
        '{10, 10, 10, 10, 10, 20, 20, 20, 30, 30, 40},
        '{10, 10, 12, 15, 21, 27, 33, 40, 48, 58, 68},
        '{8, 8, 9, 9, 9, 11, 13, 15, 20, 28, 47},
        '{27, 28, 31, 31, 35, 42, 50, 60, 70, 80, 90},
        '{20, 20, 23, 30, 39, 47, 55, 60, 66, 74, 79}
    };

    localparam logic [PRES_W-1:0] IN_GEAR_PRES [CURVE_COUNT] = '{40, 40, 40, 40, 50, 50};

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SEG_W-1:0]   seg;
        logic [FRAC_W-1:0]  frac;
        logic               shifting;
        logic               settling;
    } t_seg_item;

    typedef struct packed {
        logic [VAL_W-1:0]                    speed_x100;
        logic [CURVE_COUNT-1:0][VAL_W-1:0]   shift_val;
        logic [CURVE_COUNT-1:0][VAL_W-1:0]   pres_val;
        logic                                shifting;
        logic                                settling;
    } t_val_item;

    typedef struct packed {
        logic [VAL_W-1:0]                    speed_x100;
        logic [CURVE_COUNT-1:0][VAL_W-1:0]   shift_val;
        logic [CURVE_COUNT-1:0][PRES_W-1:0]  pres;
        logic                                shifting;
        logic                                settling;
    } t_sched_item;

endpackage

### hdl/gss_front.sv
// ---------------------------------------------------------------------------
// gss_front
// Input register with saturation, then the load segment and weight stage.
// ---------------------------------------------------------------------------
module gss_front
    import gss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_speed_mph,
    input  logic [LOAD_W-1:0] i_load_tenths,
    input  logic              i_shift_active,
    input  logic              i_post_shift_active,
    output logic              o_valid,
    input  logic              i_stall,
    output t_seg_item         o_item
);

    logic               r_a_valid;
    logic [SPEED_W-1:0] r_a_speed;
    logic [LOAD_W-1:0]  r_a_load;
    logic               r_a_shift;
    logic               r_a_settle;
    logic               r_b_valid;
    t_seg_item          r_b;

    logic               a_take;
    logic               b_take;
    logic [SPEED_W-1:0] speed_sat;
    logic [LOAD_W-1:0]  load_sat;
    logic [15:0]        seg_prod;
    logic [SEG_W-1:0]   seg;
    logic [LOAD_W-1:0]  rem;
    t_seg_item          n_b;

    assign b_take  = !r_b_valid || !i_stall;
    assign a_take  = !r_a_valid || b_take;
    assign o_stall = !a_take;

    assign speed_sat = (i_speed_mph > SPEED_IN_MAX) ? SPEED_W'(SPEED_IN_MAX)
                                                    : i_speed_mph[SPEED_W-1:0];
    assign load_sat  = (i_load_tenths > LOAD_MAX) ? LOAD_MAX : i_load_tenths;

    always_comb begin
        seg_prod     = 16'(r_a_load) * 16'(SEG_RECIP);
        seg          = seg_prod[SEG_SHIFT +: SEG_W];
        rem          = r_a_load - LOAD_W'(int'(seg) * LOAD_STEP);
        n_b.speed    = r_a_speed;
        n_b.seg      = seg;
        n_b.frac     = rem[FRAC_W-1:0];
        n_b.shifting = r_a_shift;
        n_b.settling = r_a_settle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_take) begin
                r_a_valid <= i_valid;
            end
            if (b_take) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && i_valid) begin
            r_a_speed  <= speed_sat;
            r_a_load   <= load_sat;
            r_a_shift  <= i_shift_active;
            r_a_settle <= i_post_shift_active;
        end
        if (b_take && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b;

endmodule

### hdl/gss_curves.sv
// ---------------------------------------------------------------------------
// gss_curves
// Interpolates every curve at the item's load, then scales the pressure
// curves down to whole psi.
// ---------------------------------------------------------------------------
module gss_curves
    import gss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_seg_item   i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_sched_item o_item
);

    logic        r_c_valid;
    t_val_item   r_c;
    logic        r_d_valid;
    t_sched_item r_d;

    logic              c_take;
    logic              d_take;
    logic [SEG_W-1:0]  lo;
    logic [SEG_W-1:0]  hi;
    logic [FRAC_W-1:0] wt_lo;
    logic [27:0]       pres_prod [CURVE_COUNT];
    t_val_item         n_c;
    t_sched_item       n_d;

    assign d_take  = !r_d_valid || !i_stall;
    assign c_take  = !r_c_valid || d_take;
    assign o_stall = !c_take;

    // the last point is used as is at full load
    assign lo    = (i_item.seg >= LAST_POINT) ? LAST_POINT : i_item.seg;
    assign hi    = (lo == LAST_POINT) ? LAST_POINT : lo + SEG_W'(1);
    assign wt_lo = FRAC_W'(LOAD_STEP) - i_item.frac;

    always_comb begin
        n_c.speed_x100 = VAL_W'(i_item.speed) * VAL_W'(LOAD_STEP);
        n_c.shifting   = i_item.shifting;
        n_c.settling   = i_item.settling;
        for (int c = 0; c < CURVE_COUNT; c++) begin
            n_c.shift_val[c] = VAL_W'(SPEED_TAB[c][lo]) * VAL_W'(wt_lo)
                             + VAL_W'(SPEED_TAB[c][hi]) * VAL_W'(i_item.frac);
            n_c.pres_val[c]  = VAL_W'(PRES_TAB[c][lo]) * VAL_W'(wt_lo)
                             + VAL_W'(PRES_TAB[c][hi]) * VAL_W'(i_item.frac);
        end
    end

    always_comb begin
        n_d.speed_x100 = r_c.speed_x100;
        n_d.shift_val  = r_c.shift_val;
        n_d.shifting   = r_c.shifting;
        n_d.settling   = r_c.settling;
        for (int c = 0; c < CURVE_COUNT; c++) begin
            pres_prod[c] = 28'(r_c.pres_val[c]) * 28'(PRES_RECIP);
            n_d.pres[c]  = pres_prod[c][PRES_SHIFT +: PRES_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (c_take) begin
                r_c_valid <= i_valid;
            end
            if (d_take) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take && i_valid) begin
            r_c <= n_c;
        end
        if (d_take && r_c_valid) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_d_valid;
    assign o_item  = r_d;

endmodule

### hdl/gss_decide.sv
// ---------------------------------------------------------------------------
// gss_decide
// Gear and active curve state, shift decision and the result register.
// ---------------------------------------------------------------------------
module gss_decide
    import gss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_sched_item        i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [GEAR_W-1:0]  o_gear,
    output logic               o_shift_started,
    output logic [CURVE_W-1:0] o_curve_index,
    output logic [PRES_W-1:0]  o_pressure_setpoint
);

    logic               r_valid;
    logic [GEAR_W-1:0]  r_gear;
    logic [CURVE_W-1:0] r_curve;
    logic               r_started;
    logic [PRES_W-1:0]  r_pres;

    logic               take;
    logic [CURVE_W-1:0] cur;
    logic [GEAR_W-1:0]  n_gear;
    logic [CURVE_W-1:0] n_curve;
    logic               n_started;
    logic [PRES_W-1:0]  n_pres;
    logic               up_12;
    logic               up_23;
    logic               up_34;
    logic               dn_21;
    logic               dn_32;
    logic               dn_43;

    assign take    = !r_valid || !i_stall;
    assign o_stall = !take;

    // a stored curve outside the table reads as the first up curve
    assign cur = (r_curve > CURVE_43_DN) ? CURVE_12_UP : r_curve;

    assign up_12 = i_item.speed_x100 > i_item.shift_val[CURVE_12_UP];
    assign up_23 = i_item.speed_x100 > i_item.shift_val[CURVE_23_UP];
    assign up_34 = i_item.speed_x100 > i_item.shift_val[CURVE_34_UP];
    assign dn_21 = i_item.speed_x100 < i_item.shift_val[CURVE_21_DN];
    assign dn_32 = i_item.speed_x100 < i_item.shift_val[CURVE_32_DN];
    assign dn_43 = i_item.speed_x100 < i_item.shift_val[CURVE_43_DN];

    always_comb begin
        n_gear    = r_gear;
        n_curve   = r_curve;
        n_started = 1'b0;
        n_pres    = i_item.shifting ? i_item.pres[cur] : IN_GEAR_PRES[cur];
        if (!i_item.shifting && !i_item.settling) begin
            unique case (r_gear)
                GEAR_1: begin
                    if (up_12) begin
                        n_gear  = GEAR_2;
                        n_curve = CURVE_12_UP;
                    end
                end
                GEAR_2: begin
                    priority if (up_23) begin
                        n_gear  = GEAR_3;
                        n_curve = CURVE_23_UP;
                    end else if (dn_21) begin
                        n_gear  = GEAR_1;
                        n_curve = CURVE_21_DN;
                    end else begin
                    end
                end
                GEAR_3: begin
                    priority if (up_34) begin
                        n_gear  = GEAR_4;
                        n_curve = CURVE_34_UP;
                    end else if (dn_32) begin
                        n_gear  = GEAR_2;
                        n_curve = CURVE_32_DN;
                    end else begin
                    end
                end
                GEAR_4: begin
                    if (dn_43) begin
                        n_gear  = GEAR_3;
                        n_curve = CURVE_43_DN;
                    end
                end
                default: begin
                end
            endcase
            n_started = (n_gear != r_gear);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gear  <= GEAR_1;
            r_curve <= CURVE_12_UP;
        end else if (take) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_gear  <= n_gear;
                r_curve <= n_curve;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_valid) begin
            r_started <= n_started;
            r_pres    <= n_pres;
        end
    end

    assign o_valid             = r_valid;
    assign o_gear              = r_gear;
    assign o_curve_index       = r_curve;
    assign o_shift_started     = r_started;
    assign o_pressure_setpoint = r_pres;

endmodule

### hdl/gear_shift_scheduler.sv
// ---------------------------------------------------------------------------
// gear_shift_scheduler
// Four-speed shift scheduler: interpolated shift curves, gear state and
// line pressure setpoint.
// ---------------------------------------------------------------------------
// usage
//   input channel i_in_valid / o_in_stall carries speed, load and the two
//   busy flags; an item is taken at an edge with valid high and stall low
//   output channel o_out_valid / i_out_stall returns one result per item,
//   in order: gear, shift started flag, active curve and pressure
//   an accepted item passes through the input register, segment stage,
//   curve stage, pressure scaling stage and the result register before
//   o_out_valid rises
//   throughput is one item per cycle while i_out_stall is low, set by the
//   five-stage pipeline; each stage refills as soon as the stage after it
//   moves on; a stall on the output holds the result register and the gear state;
//   empty stages ahead of it keep taking items until the pipeline is full,
//   then o_in_stall rises
//   reset (synchronous, active low) empties the pipeline and puts the block
//   in first gear with the 1-2 up curve active
// ---------------------------------------------------------------------------
module gear_shift_scheduler
    import gss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_speed_mph,
    input  logic [LOAD_W-1:0]  i_load_tenths,
    input  logic               i_shift_active,
    input  logic               i_post_shift_active,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [GEAR_W-1:0]  o_gear,
    output logic               o_shift_started,
    output logic [CURVE_W-1:0] o_curve_index,
    output logic [PRES_W-1:0]  o_pressure_setpoint
);

    logic        seg_valid;
    logic        seg_stall;
    t_seg_item   seg_item;
    logic        sched_valid;
    logic        sched_stall;
    t_sched_item sched_item;

    gss_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_in_valid),
        .o_stall             (o_in_stall),
        .i_speed_mph         (i_speed_mph),
        .i_load_tenths       (i_load_tenths),
        .i_shift_active      (i_shift_active),
        .i_post_shift_active (i_post_shift_active),
        .o_valid             (seg_valid),
        .i_stall             (seg_stall),
        .o_item              (seg_item)
    );

    gss_curves u_curves (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .o_stall (seg_stall),
        .i_item  (seg_item),
        .o_valid (sched_valid),
        .i_stall (sched_stall),
        .o_item  (sched_item)
    );

    gss_decide u_decide (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (sched_valid),
        .o_stall             (sched_stall),
        .i_item              (sched_item),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_gear              (o_gear),
        .o_shift_started     (o_shift_started),
        .o_curve_index       (o_curve_index),
        .o_pressure_setpoint (o_pressure_setpoint)
    );

endmodule

### sim/gear_shift_scheduler_tb.sv
// ---------------------------------------------------------------------------
// gear_shift_scheduler_tb
// Self-checking bench for the shift scheduler. A scoreboard class predicts
// gear, shift flag, curve and pressure for every accepted item and compares
// them in order with the results. Directed corner items come first, then a
// long run of drive-cycle sequences mixed with noise, with random gaps on
// both channels.
// ---------------------------------------------------------------------------
module gear_shift_scheduler_tb
    import gss_pkg::*;
();

    typedef struct packed {
        logic [GEAR_W-1:0]  gear;
        logic               started;
        logic [CURVE_W-1:0] curve;
        logic [PRES_W-1:0]  pres;
    } t_shift_outcome;

    class t_shift_schedule_checker;
        logic [GEAR_W-1:0] gear;
        t_curve            curve;
        bit                last_started;
        int                errors;
        t_shift_outcome    outcomes_q[$];

        function new();
            gear         = GEAR_1;
            curve        = CURVE_12_UP;
            last_started = 0;
            errors       = 0;
        endfunction

        // curve value at a load in tenths, in units of 1/1000
        function int unsigned curve_milli(t_curve c, bit want_pres, int unsigned load);
            int unsigned last;
            int unsigned pos;
            int unsigned seg;
            int unsigned frac;
            int unsigned p0;
            int unsigned p1;
            last = CURVE_POINTS - 1;
            pos  = load * last;
            seg  = pos / 1000;
            frac = pos % 1000;
            if (seg >= last) begin
                return (want_pres ? PRES_TAB[c][last] : SPEED_TAB[c][last]) * 1000;
            end
            p0 = want_pres ? PRES_TAB[c][seg] : SPEED_TAB[c][seg];
            p1 = want_pres ? PRES_TAB[c][seg + 1] : SPEED_TAB[c][seg + 1];
            return p0 * (1000 - frac) + p1 * frac;
        endfunction

        function void note_input(logic [7:0] speed_in, logic [LOAD_W-1:0] load_in,
                                 logic shifting, logic settling);
            int unsigned       spd;
            int unsigned       ld;
            int unsigned       s1000;
            logic [GEAR_W-1:0] next_gear;
            t_curve            next_curve;
            t_shift_outcome    res;
            spd   = (speed_in > SPEED_IN_MAX) ? SPEED_IN_MAX : speed_in;
            ld    = (load_in > LOAD_MAX) ? LOAD_MAX : load_in;
            s1000 = spd * 1000;
            // pressure follows the curve that was active before this decision
            if (shifting)
                res.pres = PRES_W'(curve_milli(curve, 1'b1, ld) / 1000);
            else
                res.pres = IN_GEAR_PRES[curve];
            last_started = 0;
            if (!shifting && !settling) begin
                next_gear  = gear;
                next_curve = curve;
                case (gear)
                    GEAR_1: begin
                        if (s1000 > curve_milli(CURVE_12_UP, 1'b0, ld)) begin
                            next_gear = GEAR_2; next_curve = CURVE_12_UP;
                        end
                    end
                    GEAR_2: begin
                        if (s1000 > curve_milli(CURVE_23_UP, 1'b0, ld)) begin
                            next_gear = GEAR_3; next_curve = CURVE_23_UP;
                        end else if (s1000 < curve_milli(CURVE_21_DN, 1'b0, ld)) begin
                            next_gear = GEAR_1; next_curve = CURVE_21_DN;
                        end
                    end
                    GEAR_3: begin
                        if (s1000 > curve_milli(CURVE_34_UP, 1'b0, ld)) begin
                            next_gear = GEAR_4; next_curve = CURVE_34_UP;
                        end else if (s1000 < curve_milli(CURVE_32_DN, 1'b0, ld)) begin
                            next_gear = GEAR_2; next_curve = CURVE_32_DN;
                        end
                    end
                    GEAR_4: begin
                        if (s1000 < curve_milli(CURVE_43_DN, 1'b0, ld)) begin
                            next_gear = GEAR_3; next_curve = CURVE_43_DN;
                        end
                    end
                    default: begin
                    end
                endcase
                if (next_gear != gear) begin
                    gear         = next_gear;
                    curve        = next_curve;
                    last_started = 1;
                end
            end
            res.gear    = gear;
            res.started = last_started;
            res.curve   = curve;
            outcomes_q.push_back(res);
        endfunction

        function void check_result(logic [GEAR_W-1:0] gear_out, logic started_out,
                                   logic [CURVE_W-1:0] curve_out, logic [PRES_W-1:0] pres_out);
            t_shift_outcome exp;
            if (outcomes_q.size() == 0) begin
                $display("%0t: result with no item pending: gear %0d curve %0d pres %0d",
                         $time, gear_out, curve_out, pres_out);
                errors++;
                return;
            end
            exp = outcomes_q.pop_front();
            if (gear_out !== exp.gear) begin
                $display("%0t: gear expected %0d got %0d", $time, exp.gear, gear_out);
                errors++;
            end
            if (started_out !== exp.started) begin
                $display("%0t: shift_started expected %0d got %0d",
                         $time, exp.started, started_out);
                errors++;
            end
            if (curve_out !== exp.curve) begin
                $display("%0t: curve_index expected %0d got %0d", $time, exp.curve, curve_out);
                errors++;
            end
            if (pres_out !== exp.pres) begin
                $display("%0t: pressure_setpoint expected %0d got %0d",
                         $time, exp.pres, pres_out);
                errors++;
            end
        endfunction

        function int pending();
            return outcomes_q.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 850;

    logic               i_clk;
    logic               i_rst_n             = 1'b0;
    logic               i_in_valid          = 1'b0;
    logic               o_in_stall;
    logic [7:0]         i_speed_mph         = '0;
    logic [LOAD_W-1:0]  i_load_tenths       = '0;
    logic               i_shift_active      = 1'b0;
    logic               i_post_shift_active = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall         = 1'b0;
    logic [GEAR_W-1:0]  o_gear;
    logic               o_shift_started;
    logic [CURVE_W-1:0] o_curve_index;
    logic [PRES_W-1:0]  o_pressure_setpoint;

    t_shift_schedule_checker sb;
    bit in_quiet;
    int out_stall_left;
    int out_quiet_left;
    int out_roll;

    gear_shift_scheduler DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_speed_mph         (i_speed_mph),
        .i_load_tenths       (i_load_tenths),
        .i_shift_active      (i_shift_active),
        .i_post_shift_active (i_post_shift_active),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_gear              (o_gear),
        .o_shift_started     (o_shift_started),
        .o_curve_index       (o_curve_index),
        .o_pressure_setpoint (o_pressure_setpoint)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones, none while in a quiet stretch
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [7:0] spd, logic [LOAD_W-1:0] ld, logic sh, logic st);
        int gap;
        i_in_valid          <= 1'b1;
        i_speed_mph         <= spd;
        i_load_tenths       <= ld;
        i_shift_active      <= sh;
        i_post_shift_active <= st;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_input(spd, ld, sh, st);
        gap = gap_len(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side stalls
    always @(posedge i_clk) begin
        if (out_quiet_left > 0) begin
            out_quiet_left--;
            i_out_stall <= 1'b0;
        end else if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            out_roll = $urandom_range(0, 999);
            if (out_roll < 5) begin
                out_quiet_left = $urandom_range(100, 300);
                i_out_stall    <= 1'b0;
            end else if (out_roll < 700) begin
                i_out_stall <= 1'b0;
            end else if (out_roll < 970) begin
                out_stall_left = $urandom_range(0, 2);
                i_out_stall    <= 1'b1;
            end else begin
                out_stall_left = $urandom_range(9, 39);
                i_out_stall    <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_gear, o_shift_started, o_curve_index, o_pressure_setpoint);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int spd;
        int ld;
        int shift_left;
        int settle_left;
        int r;
        logic sh;
        logic st;
        sb          = new();
        in_quiet    = 0;
        spd         = 0;
        ld          = 300;
        shift_left  = 0;
        settle_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners: saturation, full load, busy flags, every shift, equal-speed edges
        send_item(8'd0,   10'd0,    1'b0, 1'b0);
        send_item(8'd255, 10'd1023, 1'b0, 1'b0);
        send_item(8'd255, 10'd1000, 1'b1, 1'b0);
        send_item(8'd0,   10'd0,    1'b0, 1'b1);
        send_item(8'd200, 10'd500,  1'b1, 1'b1);
        send_item(8'd120, 10'd1000, 1'b0, 1'b0);
        send_item(8'd50,  10'd999,  1'b1, 1'b0);
        send_item(8'd121, 10'd1023, 1'b0, 1'b0);
        send_item(8'd0,   10'd550,  1'b1, 1'b0);
        send_item(8'd100, 10'd1000, 1'b0, 1'b0);
        send_item(8'd0,   10'd1000, 1'b0, 1'b0);
        send_item(8'd0,   10'd1000, 1'b1, 1'b0);
        send_item(8'd30,  10'd0,    1'b0, 1'b0);
        send_item(8'd31,  10'd0,    1'b0, 1'b0);
        send_item(8'd20,  10'd0,    1'b0, 1'b0);
        send_item(8'd19,  10'd0,    1'b0, 1'b0);
        send_item(8'd7,   10'd0,    1'b0, 1'b0);
        send_item(8'd1,   10'd0,    1'b0, 1'b0);
        send_item(8'd0,   10'd1,    1'b0, 1'b0);
        send_item(8'd255, 10'd1023, 1'b1, 1'b0);
        send_item(8'd128, 10'd512,  1'b0, 1'b0);
        send_item(8'd127, 10'd511,  1'b1, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                in_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // noise
                send_item(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                // drive cycle: speed and load wander, timers follow each shift
                if (r < 16)
                    spd = $urandom_range(0, 130);
                else
                    spd = spd + int'($urandom_range(0, 14)) - 7;
                if (spd < 0)
                    spd = 0;
                if (spd > 255)
                    spd = 255;
                if (r < 22)
                    ld = 100 * $urandom_range(0, 10);
                else if (r < 26)
                    ld = $urandom_range(0, 1023);
                else
                    ld = ld + int'($urandom_range(0, 120)) - 60;
                if (ld < 0)
                    ld = 0;
                if (ld > 1023)
                    ld = 1023;
                sh = (shift_left > 0);
                st = !sh && (settle_left > 0);
                send_item(8'(spd), 10'(ld), sh, st);
                if (sb.last_started) begin
                    shift_left  = $urandom_range(1, 4);
                    settle_left = $urandom_range(0, 3);
                end else if (shift_left > 0) begin
                    shift_left--;
                end else if (settle_left > 0) begin
                    settle_left--;
                end
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### gear_shift_scheduler.f
hdl/gss_pkg.sv
hdl/gss_front.sv
hdl/gss_curves.sv
hdl/gss_decide.sv
hdl/gear_shift_scheduler.sv
sim/gear_shift_scheduler_tb.sv
